FILE: rtl/core/first_fit_block_allocator_macros.svh
// Assertion macros used by the allocator sequencer.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Property checked on every rising edge of clk, switched off while rst is high.
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising edge of clk, reset cycles included.
`define FFBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/ffba_pkg.sv
// Shared constants, codes and types of the first-fit block allocator.
package ffba_pkg;

  // Table geometry and word widths.
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ADDR_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STS_W   = 2;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } cmd_e_t;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_NOFIT   = 2'd1,
    STS_NOMATCH = 2'd2
  } status_e_t;

  // Operations of the shared adder.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIT_SCAN,
    ST_HIT_WR,
    ST_REM_LEN,
    ST_ZERO_SCAN,
    ST_FREE_SCAN
  } state_t;

  // One table entry as seen on the read port.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic              used;
  } entry_t;

  // Write and flag commands from the sequencer to the table.
  typedef struct packed {
    logic              mem_we;
    logic              flag_we;
    logic              clr_all;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic              used;
  } tbl_wr_t;

  // Result and flags of the shared adder.
  typedef struct packed {
    logic [ADDR_W-1:0] sum;
    logic              ge;
    logic              zero;
  } alu_res_t;

endpackage

FILE: rtl/core/ffba_alu.sv
// Shared add/subtract unit with compare flags.
module ffba_alu (
  input  ffba_pkg::alu_op_t              op,
  input  logic [ffba_pkg::ADDR_W-1:0]    a,
  input  logic [ffba_pkg::ADDR_W-1:0]    b,
  output ffba_pkg::alu_res_t             res
);
  import ffba_pkg::*;

  logic [ADDR_W:0]   wide;
  logic [ADDR_W-1:0] b_op;

  // Subtraction is a plus the inverted b plus one; the carry then means a >= b.
  assign b_op = (op == ALU_SUB) ? ~b : b;
  assign wide = {1'b0, a} + {1'b0, b_op} + {{ADDR_W{1'b0}}, (op == ALU_SUB)};

  always_comb begin
    res.sum  = wide[ADDR_W-1:0];
    res.ge   = wide[ADDR_W];
    res.zero = (wide[ADDR_W-1:0] == '0);
  end

endmodule

FILE: rtl/core/ffba_table.sv
// Region table: start, length and used memories with per-entry valid flags.
module ffba_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ffba_pkg::IDX_W-1:0]   rd_idx,
  output ffba_pkg::entry_t             rd_data,
  input  ffba_pkg::tbl_wr_t            wr
);
  import ffba_pkg::*;

  logic [ADDR_W-1:0]  start_mem  [ENTRIES];
  logic [ADDR_W-1:0]  length_mem [ENTRIES];
  logic               used_mem   [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] valid_next;

  logic [ADDR_W-1:0]  start_q;
  logic [ADDR_W-1:0]  length_q;
  logic               valid_q;
  logic               used_q;

  // Memory write port and registered read port; a flag write changes only the used bit.
  always_ff @(posedge clk) begin
    if (wr.mem_we) begin
      start_mem[wr.idx]  <= wr.start;
      length_mem[wr.idx] <= wr.length;
      used_mem[wr.idx]   <= wr.used;
    end else if (wr.flag_we) begin
      used_mem[wr.idx] <= wr.used;
    end
    start_q  <= start_mem[rd_idx];
    length_q <= length_mem[rd_idx];
    used_q   <= used_mem[rd_idx];
  end

  // Valid flags: a clear of the whole table comes first, so an entry written in
  // the same cycle still ends up valid.
  always_comb begin
    valid_next = wr.clr_all ? '0 : valid;
    if (wr.mem_we) begin
      valid_next[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid   <= valid_next;
      valid_q <= valid[rd_idx];
    end
  end

  // An entry never written since reset or init reads as empty.
  always_comb begin
    rd_data.start  = valid_q ? start_q  : '0;
    rd_data.length = valid_q ? length_q : '0;
    rd_data.used   = valid_q & used_q;
  end

endmodule

FILE: rtl/core/ffba_ctrl.sv
// Sequencer: table scans, remainder arithmetic on the shared adder and results.
`include "first_fit_block_allocator_macros.svh"

module ffba_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ffba_pkg::CMD_W-1:0]    cmd,
  input  logic [ffba_pkg::ADDR_W-1:0]   amount,
  input  logic [ffba_pkg::ADDR_W-1:0]   start_addr,
  input  logic                          pool_size_we,
  input  logic [ffba_pkg::ADDR_W-1:0]   pool_size,
  input  ffba_pkg::entry_t              rd_data,
  output logic [ffba_pkg::IDX_W-1:0]    rd_idx,
  output ffba_pkg::tbl_wr_t             tbl_wr,
  output ffba_pkg::alu_op_t             alu_op,
  output logic [ffba_pkg::ADDR_W-1:0]   alu_a,
  output logic [ffba_pkg::ADDR_W-1:0]   alu_b,
  input  ffba_pkg::alu_res_t            alu_res,
  output logic                          busy,
  output logic                          done,
  output logic [ffba_pkg::STS_W-1:0]    status,
  output logic [ffba_pkg::ADDR_W-1:0]   region_start
);
  import ffba_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  rd_cnt, rd_cnt_next;
  logic              chk_vld, chk_vld_next;
  logic [IDX_W-1:0]  chk_idx, chk_idx_next;
  logic [ADDR_W-1:0] pool_reg;
  logic [ADDR_W-1:0] amount_q, amount_q_next;
  logic [ADDR_W-1:0] addr_q, addr_q_next;
  logic [ADDR_W-1:0] old_start, old_start_next;
  logic [ADDR_W-1:0] old_len, old_len_next;
  logic [IDX_W-1:0]  hit_idx, hit_idx_next;
  logic [ADDR_W-1:0] rem_start, rem_start_next;
  logic [ADDR_W-1:0] rem_len, rem_len_next;
  logic              done_next;
  status_e_t         status_q, status_next;
  logic [ADDR_W-1:0] region_q, region_next;
  logic              scanning;
  logic              scan_end;
  logic              match;

  assign rd_idx       = rd_cnt[IDX_W-1:0];
  assign busy         = (state != ST_IDLE);
  assign status       = status_q;
  assign region_start = region_q;

  // The read in flight is checked in the cycle after its address was issued;
  // the scan has missed once the last entry has been checked.
  assign scanning = (state == ST_FIT_SCAN) || (state == ST_ZERO_SCAN) ||
                    (state == ST_FREE_SCAN);
  assign scan_end = !chk_vld && (rd_cnt == CNT_W'(ENTRIES));

  // Pool size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_reg <= '0;
    end else if (pool_size_we) begin
      pool_reg <= pool_size;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_cnt  <= '0;
      chk_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_cnt  <= rd_cnt_next;
      chk_vld <= chk_vld_next;
      done    <= done_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chk_idx   <= chk_idx_next;
    amount_q  <= amount_q_next;
    addr_q    <= addr_q_next;
    old_start <= old_start_next;
    old_len   <= old_len_next;
    hit_idx   <= hit_idx_next;
    rem_start <= rem_start_next;
    rem_len   <= rem_len_next;
    status_q  <= status_next;
    region_q  <= region_next;
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      ST_FIT_SCAN: begin
        alu_a = rd_data.length;
        alu_b = amount_q;
      end
      ST_ZERO_SCAN: begin
        alu_a = rd_data.length;
      end
      ST_FREE_SCAN: begin
        alu_a = rd_data.start;
        alu_b = addr_q;
      end
      ST_HIT_WR: begin
        alu_op = ALU_ADD;
        alu_a  = old_start;
        alu_b  = amount_q;
      end
      ST_REM_LEN: begin
        alu_a = old_len;
        alu_b = amount_q;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  // Match condition of the scan in progress.
  always_comb begin
    case (state)
      ST_FIT_SCAN:  match = chk_vld && !rd_data.used && alu_res.ge;
      ST_ZERO_SCAN: match = chk_vld && alu_res.zero;
      ST_FREE_SCAN: match = chk_vld && alu_res.zero;
      default:      match = 1'b0;
    endcase
  end

  // Next state, scan counter, table commands and results.
  always_comb begin
    state_next     = state;
    amount_q_next  = amount_q;
    addr_q_next    = addr_q;
    old_start_next = old_start;
    old_len_next   = old_len;
    hit_idx_next   = hit_idx;
    rem_start_next = rem_start;
    rem_len_next   = rem_len;
    status_next    = status_q;
    region_next    = region_q;
    done_next      = 1'b0;
    tbl_wr         = '0;

    // The counter runs only during a scan and is cleared in every other state.
    if (scanning) begin
      rd_cnt_next  = (rd_cnt == CNT_W'(ENTRIES)) ? rd_cnt : rd_cnt + CNT_W'(1);
      chk_vld_next = (rd_cnt != CNT_W'(ENTRIES));
      chk_idx_next = rd_idx;
    end else begin
      rd_cnt_next  = '0;
      chk_vld_next = 1'b0;
      chk_idx_next = chk_idx;
    end

    case (state)
      ST_IDLE: begin
        if (start) begin
          amount_q_next = amount;
          addr_q_next   = start_addr;
          case (cmd_e_t'(cmd))
            CMD_ALLOC: state_next = ST_FIT_SCAN;
            CMD_FREE:  state_next = ST_FREE_SCAN;
            CMD_INIT: begin
              tbl_wr.clr_all = 1'b1;
              tbl_wr.mem_we  = 1'b1;
              tbl_wr.idx     = '0;
              tbl_wr.start   = '0;
              tbl_wr.length  = pool_reg;
              tbl_wr.used    = 1'b0;
              done_next      = 1'b1;
              status_next    = STS_OK;
              region_next    = '0;
            end
            default: begin
              done_next   = 1'b1;
              status_next = STS_OK;
              region_next = '0;
            end
          endcase
        end
      end

      // First free entry that is long enough.
      ST_FIT_SCAN: begin
        if (match) begin
          old_start_next = rd_data.start;
          old_len_next   = rd_data.length;
          hit_idx_next   = chk_idx;
          state_next     = ST_HIT_WR;
        end else if (scan_end) begin
          done_next   = 1'b1;
          status_next = STS_NOFIT;
          region_next = '0;
          state_next  = ST_IDLE;
        end
      end

      // Shrink the hit entry and mark it used; the adder forms the new start.
      ST_HIT_WR: begin
        tbl_wr.mem_we  = 1'b1;
        tbl_wr.idx     = hit_idx;
        tbl_wr.start   = old_start;
        tbl_wr.length  = amount_q;
        tbl_wr.used    = 1'b1;
        rem_start_next = alu_res.sum;
        state_next     = ST_REM_LEN;
      end

      // Length of the remainder.
      ST_REM_LEN: begin
        rem_len_next = alu_res.sum;
        state_next   = ST_ZERO_SCAN;
      end

      // First empty slot takes the remainder; with no slot it is dropped.
      ST_ZERO_SCAN: begin
        if (match) begin
          tbl_wr.mem_we = 1'b1;
          tbl_wr.idx    = chk_idx;
          tbl_wr.start  = rem_start;
          tbl_wr.length = rem_len;
          tbl_wr.used   = 1'b0;
        end
        if (match || scan_end) begin
          done_next   = 1'b1;
          status_next = STS_OK;
          region_next = old_start;
          state_next  = ST_IDLE;
        end
      end

      // First entry with a matching start is released.
      ST_FREE_SCAN: begin
        if (match) begin
          tbl_wr.flag_we = 1'b1;
          tbl_wr.idx     = chk_idx;
          tbl_wr.used    = 1'b0;
          done_next      = 1'b1;
          status_next    = STS_OK;
          region_next    = '0;
          state_next     = ST_IDLE;
        end else if (scan_end) begin
          done_next   = 1'b1;
          status_next = STS_NOMATCH;
          region_next = '0;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A result follows either work in progress or a command finished on transfer.
  `FFBA_ASSERT(a_done_cause,
               done |-> $past(state != ST_IDLE || start),
               "result without a command")
  // An allocate always starts with the fit scan.
  `FFBA_ASSERT(a_alloc_scan,
               (start && !busy && cmd == CMD_ALLOC) |=> (state == ST_FIT_SCAN),
               "allocate did not enter the fit scan")
  // The hit entry is written only straight after a fit scan found it.
  `FFBA_ASSERT(a_hit_order,
               (state == ST_HIT_WR) |-> ($past(state) == ST_FIT_SCAN),
               "hit write out of order")
  // The scan counter never runs past the table; it is only defined once reset is seen.
  `FFBA_ASSERT_ALWAYS(a_cnt_range,
                      rst || (rd_cnt <= CNT_W'(ENTRIES)),
                      "scan counter beyond table")

endmodule

FILE: rtl/core/first_fit_block_allocator.sv
// Top level of the first-fit block allocator.
// Commands are transferred when start is high and busy is low; each gives one
// result, shown for exactly one cycle with done high, which the receiver must
// take as it comes. The table is read one entry per cycle through its single
// registered read port. Init and the unused command give their result without
// a scan, a free scans the table for a matching start, and an allocate runs a
// fit scan, two adder steps and a scan for an empty slot. busy stays high while
// a free or an allocate runs and falls in the cycle in which done is shown, so
// the next command can be transferred while the result is on the ports.
// pool_size is written with pool_size_we and takes effect at the next init.
module first_fit_block_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffba_pkg::CMD_W-1:0]    cmd,
  input  logic [ffba_pkg::ADDR_W-1:0]   amount,
  input  logic [ffba_pkg::ADDR_W-1:0]   start_addr,
  input  logic                          pool_size_we,
  input  logic [ffba_pkg::ADDR_W-1:0]   pool_size,
  output logic                          done,
  output logic [ffba_pkg::STS_W-1:0]    status,
  output logic [ffba_pkg::ADDR_W-1:0]   region_start
);
  import ffba_pkg::*;

  logic [IDX_W-1:0]  rd_idx;
  entry_t            rd_data;
  tbl_wr_t           tbl_wr;
  alu_op_t           alu_op;
  logic [ADDR_W-1:0] alu_a;
  logic [ADDR_W-1:0] alu_b;
  alu_res_t          alu_res;

  // Sequencer.
  ffba_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .amount       (amount),
    .start_addr   (start_addr),
    .pool_size_we (pool_size_we),
    .pool_size    (pool_size),
    .rd_data      (rd_data),
    .rd_idx       (rd_idx),
    .tbl_wr       (tbl_wr),
    .alu_op       (alu_op),
    .alu_a        (alu_a),
    .alu_b        (alu_b),
    .alu_res      (alu_res),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .region_start (region_start)
  );

  // Region table.
  ffba_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr      (tbl_wr)
  );

  // Shared adder for compares and remainder arithmetic.
  ffba_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

endmodule

FILE: sim/first_fit_block_allocator_tb.sv
// Self-checking testbench for the first-fit block allocator: directed and random commands.
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  // Command code that the block leaves unused.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Longest time from a command to its result, with margin.
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] amount;
    logic [ADDR_W-1:0] addr;
  } alloc_cmd_t;

  typedef struct {
    status_e_t         status;
    logic [ADDR_W-1:0] region_start;
  } alloc_outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  cmd = CMD_UNUSED;
  logic [ADDR_W-1:0] amount = '0;
  logic [ADDR_W-1:0] start_addr = '0;
  logic              pool_size_we = 1'b0;
  logic [ADDR_W-1:0] pool_size = '0;
  logic              done;
  logic [STS_W-1:0]  status;
  logic [ADDR_W-1:0] region_start;

  // Commands waiting to be driven, and results still owed by the block.
  alloc_cmd_t     cmd_backlog[$];
  alloc_outcome_t owed_outcomes[$];
  alloc_cmd_t     cur_cmd;
  int             gap_pct = 0;
  int             errors = 0;
  int             stall_cycles = 0;

  // Shadow of the region table and of the pool size register.
  logic [ADDR_W-1:0] pool_bytes = '0;
  bit [ADDR_W-1:0]   tbl_start[ENTRIES];
  bit [ADDR_W-1:0]   tbl_len[ENTRIES];
  bit                tbl_used[ENTRIES];
  // Starts handed out since the last init, used to aim frees at real regions.
  logic [ADDR_W-1:0] live_starts[$];

  first_fit_block_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .amount       (amount),
    .start_addr   (start_addr),
    .pool_size_we (pool_size_we),
    .pool_size    (pool_size),
    .done         (done),
    .status       (status),
    .region_start (region_start)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Empty the table and load the whole pool into entry zero.
  function automatic void clear_table();
    foreach (tbl_start[i]) begin
      tbl_start[i] = '0;
      tbl_len[i]   = '0;
      tbl_used[i]  = 1'b0;
    end
    tbl_len[0] = pool_bytes;
    live_starts.delete();
  endfunction

  // Apply one command to the shadow table and return the result it gives.
  function automatic alloc_outcome_t apply_command(alloc_cmd_t c);
    alloc_outcome_t    res;
    int                hit;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] span;
    res.status       = STS_OK;
    res.region_start = '0;
    hit              = -1;
    case (c.cmd)
      CMD_ALLOC: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!tbl_used[i] && tbl_len[i] >= c.amount) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          res.status = STS_NOFIT;
        end else begin
          base = tbl_start[hit];
          span = tbl_len[hit];
          tbl_len[hit]     = c.amount;
          tbl_used[hit]    = 1'b1;
          res.region_start = base;
          live_starts.push_back(base);
          // The remainder goes to the first empty slot, or is lost when there is none.
          for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_len[i] == '0) begin
              tbl_start[i] = base + c.amount;
              tbl_len[i]   = span - c.amount;
              tbl_used[i]  = 1'b0;
              break;
            end
          end
        end
      end
      CMD_FREE: begin
        res.status = STS_NOMATCH;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_start[i] == c.addr) begin
            tbl_used[i] = 1'b0;
            res.status  = STS_OK;
            break;
          end
        end
      end
      CMD_INIT: clear_table();
      default: ;
    endcase
    return res;
  endfunction

  // Driver: predicts each accepted transfer and offers the next command.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        owed_outcomes.push_back(apply_command(cur_cmd));
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= gap_pct) begin
          cur_cmd    <= cmd_backlog[0];
          cmd        <= cmd_backlog[0].cmd;
          amount     <= cmd_backlog[0].amount;
          start_addr <= cmd_backlog[0].addr;
          void'(cmd_backlog.pop_front());
          start      <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result strobe is checked against the oldest owed result.
  always @(posedge clk) begin
    alloc_outcome_t want;
    if (!rst && done) begin
      if (owed_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with none owed: status %0h region_start %0h",
                 $time, status, region_start);
      end else begin
        want = owed_outcomes.pop_front();
        if (status !== want.status) begin
          errors++;
          $display("%0t: status expected %0h, got %0h", $time, want.status, status);
        end
        if (region_start !== want.region_start) begin
          errors++;
          $display("%0t: region_start expected %0h, got %0h",
                   $time, want.region_start, region_start);
        end
      end
    end
  end

  // Watchdog on cycles with neither a command nor a result transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_cmd(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] amt,
                           logic [ADDR_W-1:0] addr);
    alloc_cmd_t item;
    item.cmd    = c;
    item.amount = amt;
    item.addr   = addr;
    cmd_backlog.push_back(item);
  endtask

  // Wait until every command has been transferred and every result seen.
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || owed_outcomes.size() != 0);
  endtask

  // Change the pool size only while the block has nothing in hand.
  task automatic write_pool(logic [ADDR_W-1:0] value);
    wait_idle();
    @(posedge clk);
    pool_size_we <= 1'b1;
    pool_size    <= value;
    pool_bytes    = value;
    @(posedge clk);
    pool_size_we <= 1'b0;
  endtask

  // Mostly allocations sized to the pool and frees of handed-out starts, with noise.
  function automatic alloc_cmd_t make_random_cmd();
    alloc_cmd_t c;
    int         pick;
    pick     = $urandom_range(99);
    c.amount = $urandom;
    c.addr   = $urandom;
    if (pick < 1) begin
      c.cmd = CMD_INIT;
    end else if (pick < 3) begin
      c.cmd = CMD_UNUSED;
    end else if (pick < 58) begin
      c.cmd = CMD_ALLOC;
      pick  = $urandom_range(99);
      if (pick < 8)       c.amount = $urandom;
      else if (pick < 14) c.amount = '0;
      else if (pick < 18) c.amount = pool_bytes;
      else                c.amount = $urandom_range(0, (pool_bytes >> 6) + 1);
    end else begin
      c.cmd = CMD_FREE;
      pick  = $urandom_range(99);
      if (pick < 70 && live_starts.size() > 0)
        c.addr = live_starts[$urandom_range(0, live_starts.size() - 1)];
      else if (pick < 85)
        c.addr = $urandom_range(0, pool_bytes);
    end
    return c;
  endfunction

  // One random phase: a pool size, an idle rate for the sender, and a stream of commands.
  task automatic run_phase(logic [ADDR_W-1:0] pool, int pct, int count);
    write_pool(pool);
    gap_pct = pct;
    queue_cmd(CMD_INIT, '0, '0);
    for (int n = 0; n < count; n++) begin
      while (cmd_backlog.size() > 1) @(negedge clk);
      if (n % 40 == 0) gap_pct = ($urandom_range(3) == 0) ? 0 : pct;
      cmd_backlog.push_back(make_random_cmd());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Table straight out of reset: every entry reads as a free region of zero length at offset zero.
    queue_cmd(CMD_ALLOC, 32'd0, '0);
    queue_cmd(CMD_ALLOC, 32'd1, '0);
    queue_cmd(CMD_FREE, '0, 32'd0);
    queue_cmd(CMD_FREE, '0, 32'hFFFF_FFFF);
    queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Small pool: zero-size allocation, exact fit, double free and misses.
    write_pool(32'd1000);
    queue_cmd(CMD_INIT, '0, '0);
    queue_cmd(CMD_ALLOC, 32'd0, '0);
    queue_cmd(CMD_ALLOC, 32'd100, '0);
    queue_cmd(CMD_ALLOC, 32'd1000, '0);
    queue_cmd(CMD_ALLOC, 32'd900, '0);
    queue_cmd(CMD_FREE, '0, 32'd100);
    queue_cmd(CMD_FREE, '0, 32'd100);
    queue_cmd(CMD_FREE, '0, 32'd5);
    queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF, '0);

    // Full-width pool: halves, an empty slot at the top offset, and the largest request.
    write_pool(32'hFFFF_FFFF);
    queue_cmd(CMD_INIT, '0, '0);
    queue_cmd(CMD_ALLOC, 32'h8000_0000, '0);
    queue_cmd(CMD_ALLOC, 32'h7FFF_FFFF, '0);
    queue_cmd(CMD_ALLOC, 32'd1, '0);
    queue_cmd(CMD_ALLOC, 32'd0, '0);
    queue_cmd(CMD_FREE, '0, 32'hFFFF_FFFF);
    queue_cmd(CMD_FREE, '0, 32'h8000_0000);
    queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF, '0);

    run_phase(32'd4096, 0, 132);
    run_phase(32'hFFFF_FFFF, 62, 132);
    run_phase($urandom, 0, 132);
    run_phase($urandom_range(1, 300), 29, 132);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_alu.sv
rtl/core/ffba_table.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator.sv
sim/first_fit_block_allocator_tb.sv
